/* rtl/kfs_pkg.sv */
`timescale 1ns / 1ps

package kfs_pkg;

  localparam int DEPTH     = 16;
  localparam int KEY_BITS  = 16;
  localparam int DATA_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_ENQ    = 2'd0,
    ACT_DEQ    = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_LIST   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_SINGLE,
    S_WALK
  } state_t;

  typedef struct packed {
    action_t                action;
    logic [KEY_BITS-1:0]    key;
    logic [DATA_BITS-1:0]   payload;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic [KEY_BITS-1:0]    entry_key;
    logic [DATA_BITS-1:0]   entry_data;
    logic [CNT_W-1:0]       entry_count;
    logic                   last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;         // capture the input transaction
    logic rd_start;     // read the head entry, walk index to zero
    logic rd_next;      // advance the walk index and read that entry
    logic emit_single;  // enqueue, dequeue, or lookup or list on an empty queue
    logic emit_found;   // lookup hit on the entry under the walk
    logic emit_miss;    // lookup walked to the tail without a hit
    logic emit_list;    // list result for the entry under the walk
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    action_t action;
    logic    empty;
    logic    match;
    logic    is_last;
    logic    out_free;
  } dp_stat_t;

endpackage

/* rtl/kfs_ctrl.sv */
`timescale 1ns / 1ps

module kfs_ctrl
  import kfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.action inside {ACT_ENQ, ACT_DEQ} || stat.empty) begin
          state_nxt = S_SINGLE;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_SINGLE: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        if (stat.out_free && (stat.match && stat.action == ACT_LOOKUP || stat.is_last)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DISPATCH: begin
        cmd.rd_start = !(stat.action inside {ACT_ENQ, ACT_DEQ}) && !stat.empty;
      end
      S_SINGLE: begin
        cmd.emit_single = stat.out_free;
      end
      S_WALK: begin
        if (stat.action == ACT_LOOKUP) begin
          if (stat.match) begin
            cmd.emit_found = stat.out_free;
          end else if (stat.is_last) begin
            cmd.emit_miss = stat.out_free;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end else begin
          cmd.emit_list = stat.out_free;
          cmd.rd_next   = stat.out_free && !stat.is_last;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/kfs_dp.sv */
`timescale 1ns / 1ps

module kfs_dp
  import kfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat
);

  logic [KEY_BITS-1:0]  key_mem  [DEPTH];
  logic [DATA_BITS-1:0] data_mem [DEPTH];

  in_item_t             item_r;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [IDX_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [KEY_BITS-1:0]  rd_key_r;
  logic [DATA_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]     rd_addr;
  logic                 rd_en;
  logic                 full;
  logic                 do_write;
  out_item_t            res;
  logic                 emit;
  logic                 out_valid_r;
  out_item_t            out_r;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign emit  = cmd.emit_single | cmd.emit_found | cmd.emit_miss | cmd.emit_list;

  assign stat.action   = item_r.action;
  assign stat.empty    = (cnt_r == '0);
  assign stat.match    = (rd_key_r == item_r.key);
  assign stat.is_last  = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);
  assign stat.out_free = !out_valid_r || out_ready;

  // Walk index and ring read address
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.rd_start) begin
      idx_nxt = '0;
    end else if (cmd.rd_next) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  assign rd_en   = cmd.rd_start | cmd.rd_next;
  assign rd_addr = head_r + idx_nxt;

  // Pointer and count updates, result formation
  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    cnt_nxt         = cnt_r;
    do_write        = 1'b0;
    res             = '0;
    res.last        = 1'b1;
    if (cmd.emit_single) begin
      case (item_r.action)
        ACT_ENQ: begin
          if (full) begin
            res.status = ST_FULL;
          end else begin
            do_write   = 1'b1;
            tail_nxt   = tail_r + IDX_W'(1);
            cnt_nxt    = cnt_r + CNT_W'(1);
            res.status = ST_OK;
          end
        end
        ACT_DEQ: begin
          if (cnt_r == '0) begin
            res.status = ST_EMPTY;
          end else begin
            head_nxt   = head_r + IDX_W'(1);
            cnt_nxt    = cnt_r - CNT_W'(1);
            res.status = ST_OK;
          end
        end
        ACT_LOOKUP: res.status = ST_NOT_FOUND;
        default:    res.status = ST_EMPTY;
      endcase
    end else if (cmd.emit_found) begin
      res.status     = ST_OK;
      res.entry_key  = rd_key_r;
      res.entry_data = rd_data_r;
    end else if (cmd.emit_miss) begin
      res.status = ST_NOT_FOUND;
    end else begin
      res.status    = ST_OK;
      res.entry_key = rd_key_r;
      res.last      = stat.is_last;
    end
    res.entry_count = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (emit) begin
      out_r <= res;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_write) begin
      key_mem[tail_r]  <= item_r.key;
      data_mem[tail_r] <= item_r.payload;
    end
    if (rd_en) begin
      rd_key_r  <= key_mem[rd_addr];
      rd_data_r <= data_mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/keyed_fifo_with_search.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// -------  ---------  -----------------  ---------------------------------------------
// in_      input      in_valid/in_ready  in_item_t: action, key, payload
// out_     output     out_valid/out_ready out_item_t: status, entry_key, entry_data,
//                                          entry_count, last
//
// One transaction is taken at a time. Enqueue and dequeue pass through capture,
// dispatch and the single-result state before their result is registered; lookup
// and list walk the entries from the head, ending at a lookup hit or the tail,
// paced by the single read port of the entry memory.
// Reset (rst_n low, synchronous) empties the queue; entry memory is not cleared.
// A full output register stalls the controller and holds the walk in place;
// a new input transaction is taken once the previous one has issued its final result.

module keyed_fifo_with_search
  import kfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer: capture, dispatch, single result or head-to-tail walk
  kfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Ring storage, pointers, count and the output register
  kfs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
